[rtl/kacc_pkg.sv]
// ----------------------------------------------------------------------------
// kacc_pkg
// Shared types and constants for the keypad alarm clock controller.
// ----------------------------------------------------------------------------
package kacc_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_TIME   = 2'd1,
    MODE_ALARM  = 2'd2,
    MODE_THRESH = 2'd3
  } mode_t;

  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] key_code;
    logic [9:0] temp_sample;
  } req_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [1:0] mode_now;
    logic [1:0] cursor_now;
    logic       buzzer_on;
    logic       alarm_armed;
    logic [6:0] threshold_value;
    logic       heat_latched;
  } rsp_t;

  // Classified event handed from front to back.
  typedef struct packed {
    logic       is_tick;
    logic       is_digit;
    logic [3:0] key_code;
    logic [9:0] temp_sample;
  } evt_t;

endpackage

[rtl/kacc_front.sv]
// ----------------------------------------------------------------------------
// kacc_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module kacc_front #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  kacc_pkg::req_t  req,
  output logic            evt_valid,
  input  logic            evt_take,
  output kacc_pkg::evt_t  evt
);
  import kacc_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  evt_t            mem [Depth];
  logic [Aw-1:0]   wr_ptr;
  logic [Aw-1:0]   rd_ptr;
  logic [Aw:0]     count;
  evt_t            classified;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    classified.is_tick     = (req.req_type == REQ_TICK);
    classified.is_digit    = (req.key_code <= 4'd9);
    classified.key_code    = req.key_code;
    classified.temp_sample = req.temp_sample;
  end

  assign full      = (count == (Aw+1)'(Depth));
  assign evt_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = evt_take && evt_valid;
  assign evt       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

endmodule

[rtl/kacc_back.sv]
// ----------------------------------------------------------------------------
// kacc_back
// Carries out events on the clock state and holds the result register.
// ----------------------------------------------------------------------------
module kacc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            evt_valid,
  output logic            evt_take,
  input  kacc_pkg::evt_t  evt,
  output logic            empty,
  input  logic            pop,
  output kacc_pkg::rsp_t  rsp
);
  import kacc_pkg::*;

  logic [3:0] t [6];
  logic [3:0] al [4];
  logic [3:0] th [2];
  mode_t      mode_reg;
  logic [1:0] cursor_reg;
  logic       clock_running, armed_flag, heat_flag, buzzer_reg;
  logic [9:0] last_sample;

  logic [3:0] t_next [6];
  logic [3:0] al_next [4];
  logic [3:0] th_next [2];
  mode_t      mode_next;
  logic [1:0] cursor_next;
  logic       running_next, armed_next, heat_next, buzzer_next;
  logic [9:0] sample_next;
  logic [3:0] d [4];
  logic       hm_edit;
  logic       hm_alarm;
  logic [6:0] thr;
  logic [18:0] lhs;
  logic [17:0] rhs;
  logic       hot;
  logic       rsp_valid;
  logic       step;

  assign empty    = !rsp_valid;
  assign evt_take = !rsp_valid || pop;
  assign step     = evt_valid && evt_take;

  always_comb begin
    t_next       = t;
    al_next      = al;
    th_next      = th;
    mode_next    = mode_reg;
    cursor_next  = cursor_reg;
    running_next = clock_running;
    armed_next   = armed_flag;
    heat_next    = heat_flag;
    buzzer_next  = buzzer_reg;
    sample_next  = last_sample;
    hm_edit      = 1'b0;
    hm_alarm     = 1'b0;
    if (evt.is_tick) begin
      if (clock_running) begin
        // advance one second with BCD carries
        sample_next = evt.temp_sample;
        t_next[5] = t[5] + 4'd1;
        if (t_next[5] >= 4'd10) begin t_next[5] = '0; t_next[4] = t[4] + 4'd1; end
        if (t_next[4] >= 4'd6) begin t_next[4] = '0; t_next[3] = t[3] + 4'd1; end
        if (t_next[3] >= 4'd10) begin t_next[3] = '0; t_next[2] = t[2] + 4'd1; end
        if (t_next[2] >= 4'd6) begin t_next[2] = '0; t_next[1] = t[1] + 4'd1; end
        if (t_next[0] >= 4'd2) begin
          if (t_next[1] >= 4'd4) begin t_next[0] = '0; t_next[1] = '0; end
        end else if (t_next[1] >= 4'd10) begin
          t_next[1] = '0;
          t_next[0] = t[0] + 4'd1;
        end
      end
    end else begin
      unique case (mode_reg)
        MODE_RUN: begin
          priority if (evt.key_code == KEY_A) begin
            mode_next = MODE_TIME; cursor_next = '0;
          end else if (evt.key_code == KEY_B) begin
            mode_next = MODE_ALARM; cursor_next = '0;
          end else if (evt.key_code == KEY_STAR) begin
            mode_next = MODE_THRESH; cursor_next = '0;
          end else if (evt.key_code == KEY_C) begin
            buzzer_next = 1'b0;
          end else begin
            // drop digits, D and hash
          end
        end
        MODE_TIME: begin
          t_next[4] = '0;
          t_next[5] = '0;
          if (evt.key_code == KEY_D) begin
            running_next = 1'b1; mode_next = MODE_RUN; cursor_next = '0;
          end else begin
            hm_edit = 1'b1;
          end
        end
        MODE_ALARM: begin
          priority if (evt.key_code == KEY_C) begin
            mode_next = MODE_RUN; cursor_next = '0;
          end else if (evt.key_code == KEY_D) begin
            armed_next = 1'b1; mode_next = MODE_RUN; cursor_next = '0;
          end else begin
            hm_edit = 1'b1; hm_alarm = 1'b1;
          end
        end
        MODE_THRESH: begin
          priority if (evt.key_code == KEY_D) begin
            mode_next = MODE_RUN; cursor_next = '0;
          end else if (evt.key_code == KEY_HASH) begin
            cursor_next = 2'd1;
          end else if (evt.key_code == KEY_STAR) begin
            cursor_next = 2'd0;
          end else if (evt.is_digit) begin
            th_next[cursor_reg[0]] = evt.key_code;
          end else begin
            // drop A, B and C
          end
        end
        default: ;
      endcase
    end

    // shared hh:mm editor for set time and set alarm
    for (int i = 0; i < 4; i++) d[i] = hm_alarm ? al[i] : t[i];
    if (hm_edit) begin
      priority if (evt.is_digit) begin
        unique case (cursor_reg)
          2'd0: if (evt.key_code <= 4'd1 || (evt.key_code == 4'd2 && d[1] <= 4'd3))
                  d[0] = evt.key_code;
          2'd1: if (!(d[0] == 4'd2 && evt.key_code > 4'd3)) d[1] = evt.key_code;
          2'd2: if (evt.key_code <= 4'd5) d[2] = evt.key_code;
          default: d[3] = evt.key_code;
        endcase
      end else if (evt.key_code == KEY_HASH) begin
        cursor_next = cursor_reg + 2'd1;
      end else if (evt.key_code == KEY_STAR) begin
        cursor_next = cursor_reg - 2'd1;
      end else begin
        // drop A, B and C
      end
      if (hm_alarm) begin
        for (int i = 0; i < 4; i++) al_next[i] = d[i];
      end else begin
        for (int i = 0; i < 4; i++) t_next[i] = d[i];
      end
    end

    thr = 7'(th_next[0]) * 7'd10 + 7'(th_next[1]);
    lhs = 19'(sample_next) * 19'd330;
    rhs = {(8'(thr) + 8'd50), 10'd0};
    hot = (lhs >= 19'(rhs));
    if (mode_next == MODE_RUN) begin
      if (armed_next && t_next[0] == al_next[0] && t_next[1] == al_next[1] &&
          t_next[2] == al_next[2] && t_next[3] == al_next[3]) begin
        buzzer_next = 1'b1;
        armed_next  = 1'b0;
      end
      if (hot) begin
        if (!heat_next) begin buzzer_next = 1'b1; heat_next = 1'b1; end
      end else begin
        heat_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) t[i] <= '0;
      for (int i = 0; i < 4; i++) al[i] <= '0;
      th[0]         <= 4'd9;
      th[1]         <= 4'd9;
      mode_reg      <= MODE_TIME;
      cursor_reg    <= '0;
      clock_running <= 1'b0;
      armed_flag    <= 1'b0;
      heat_flag     <= 1'b0;
      buzzer_reg    <= 1'b0;
      last_sample   <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (step) begin
        t             <= t_next;
        al            <= al_next;
        th            <= th_next;
        mode_reg      <= mode_next;
        cursor_reg    <= cursor_next;
        clock_running <= running_next;
        armed_flag    <= armed_next;
        heat_flag     <= heat_next;
        buzzer_reg    <= buzzer_next;
        last_sample   <= sample_next;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (pop) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.hour_tens       <= t_next[0][1:0];
      rsp.hour_units      <= t_next[1];
      rsp.minute_tens     <= t_next[2][2:0];
      rsp.minute_units    <= t_next[3];
      rsp.second_tens     <= t_next[4][2:0];
      rsp.second_units    <= t_next[5];
      rsp.mode_now        <= mode_next;
      rsp.cursor_now      <= (mode_next == MODE_RUN) ? 2'd0 : cursor_next;
      rsp.buzzer_on       <= buzzer_next;
      rsp.alarm_armed     <= armed_next;
      rsp.threshold_value <= thr;
      rsp.heat_latched    <= heat_next;
    end
  end

endmodule

[rtl/keypad_alarm_clock_controller.sv]
// ----------------------------------------------------------------------------
// keypad_alarm_clock_controller
// BCD 24-hour alarm clock with keypad editing and a temperature alarm.
// ----------------------------------------------------------------------------
// Usage: write request transactions (one-second tick with a temperature
// sample, or a decoded key) with push while full is low. Every request
// gives exactly one result transaction: the time digits, mode, cursor,
// threshold and alarm flags after the event. Read results with pop while
// empty is low; the oldest result sits on rsp.
// Path: a request passes through the event queue and then the result
// register before it shows up as a result.
// Throughput: one transaction per cycle while results are popped, set by
// the back end; the result register refills in the cycle it is popped.
// When the receiver stalls, the result register holds, the back end stops
// draining the event queue, and full rises once the queue is full.
// Reset (rst, synchronous): clock 00:00:00 stopped, set-time mode, cursor
// at hour tens, threshold 99, alarm disarmed, buzzer off, queues empty.
// ----------------------------------------------------------------------------
module keypad_alarm_clock_controller #(
  parameter int unsigned QueueDepth = kacc_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  kacc_pkg::req_t  req,
  output logic            empty,
  input  logic            pop,
  output kacc_pkg::rsp_t  rsp
);
  import kacc_pkg::*;

  logic evt_valid;
  logic evt_take;
  evt_t evt;

  // Front: accept and classify requests into the event queue.
  kacc_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .push, .full, .req,
    .evt_valid, .evt_take, .evt
  );

  // Back: apply events to the clock state and hold the result.
  kacc_back u_back (
    .clk, .rst, .evt_valid, .evt_take, .evt,
    .empty, .pop, .rsp
  );

  // An event is only drained when the result register can take it.
  a_take_room: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_take) |=> !empty)
    else $error("event drained without producing a result");

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(rsp))
    else $error("result changed while stalled");

  // Run mode always reports cursor zero.
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.mode_now == MODE_RUN) |-> (rsp.cursor_now == 2'd0))
    else $error("cursor nonzero in run mode");

endmodule
